// ===== rtl/aabb_cr_pkg.sv =====
package aabb_cr_pkg;

    // Input transaction kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Contact side codes
    localparam logic [2:0] SIDE_NONE   = 3'd0;
    localparam logic [2:0] SIDE_TOP    = 3'd1;
    localparam logic [2:0] SIDE_BOTTOM = 3'd2;
    localparam logic [2:0] SIDE_LEFT   = 3'd3;
    localparam logic [2:0] SIDE_RIGHT  = 3'd4;

    // Per-pair geometry flags carried from the pair stage to the resolver
    typedef struct packed {
        logic hit_ok;     // entry qualifies and the boxes strictly overlap
        logic right;      // query center lies right of the stored center
        logic below;      // query center lies below the stored center
        logic contain_h;  // query sits horizontally inside the stored box
        logic contain_v;  // query sits vertically inside the stored box
    } pair_flags_t;

endpackage

// ===== rtl/aabb_cr_geom.sv =====
module aabb_cr_geom #(
    parameter int COORD_BITS = 16,
    parameter int IDX_BITS   = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         clear,
    input  logic                         in_valid,
    input  logic                         in_qual,
    input  logic [IDX_BITS-1:0]          in_slot,
    input  logic signed [COORD_BITS-1:0] a_left,
    input  logic signed [COORD_BITS-1:0] a_top,
    input  logic signed [COORD_BITS-1:0] a_right,
    input  logic signed [COORD_BITS-1:0] a_bottom,
    input  logic [4*COORD_BITS-1:0]      b_box,
    output logic                         out_valid,
    output aabb_cr_pkg::pair_flags_t     out_flags,
    output logic signed [COORD_BITS:0]   out_dx,
    output logic signed [COORD_BITS:0]   out_dy,
    output logic [IDX_BITS-1:0]          out_slot
);
    import aabb_cr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int OW = COORD_BITS + 1;

    logic signed [CW-1:0] b_left, b_top, b_right, b_bottom;
    logic signed [OW-1:0] cxa, cxb, cya, cyb;
    logic signed [OW-1:0] dx_r, dx_l, dy_b, dy_t;
    logic                 ovl_x, ovl_y;
    pair_flags_t          flags;

    logic                 valid_reg;
    pair_flags_t          flags_reg;
    logic signed [OW-1:0] dx_reg, dy_reg;
    logic [IDX_BITS-1:0]  slot_reg;

    // Stored box layout: left, top, right, bottom from the top bits down
    assign b_left   = $signed(b_box[4*CW-1 -: CW]);
    assign b_top    = $signed(b_box[3*CW-1 -: CW]);
    assign b_right  = $signed(b_box[2*CW-1 -: CW]);
    assign b_bottom = $signed(b_box[CW-1 -: CW]);

    // Strict overlap: max(lo) < min(hi) split into four independent compares
    assign ovl_x = (a_left < a_right) && (b_left < b_right) &&
                   (a_left < b_right) && (b_left < a_right);
    assign ovl_y = (a_top < a_bottom) && (b_top < b_bottom) &&
                   (a_top < b_bottom) && (b_top < a_bottom);

    // Doubled centers, no halving needed
    assign cxa = {a_left[CW-1], a_left} + {a_right[CW-1], a_right};
    assign cxb = {b_left[CW-1], b_left} + {b_right[CW-1], b_right};
    assign cya = {a_top[CW-1], a_top} + {a_bottom[CW-1], a_bottom};
    assign cyb = {b_top[CW-1], b_top} + {b_bottom[CW-1], b_bottom};

    // Candidate depths on each axis, picked by center position
    assign dx_r = {b_right[CW-1], b_right} - {a_left[CW-1], a_left};
    assign dx_l = {a_right[CW-1], a_right} - {b_left[CW-1], b_left};
    assign dy_b = {b_bottom[CW-1], b_bottom} - {a_top[CW-1], a_top};
    assign dy_t = {a_bottom[CW-1], a_bottom} - {b_top[CW-1], b_top};

    always_comb begin
        flags.hit_ok    = in_qual && ovl_x && ovl_y;
        flags.right     = cxa > cxb;
        flags.below     = cya > cyb;
        flags.contain_h = (a_left > b_left) && (a_right < b_right);
        flags.contain_v = (a_top > b_top) && (a_bottom < b_bottom);
    end

    // Pair stage register, held while the resolver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            flags_reg <= flags;
            dx_reg    <= flags.right ? dx_r : dx_l;
            dy_reg    <= flags.below ? dy_b : dy_t;
            slot_reg  <= in_slot;
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_dx    = dx_reg;
    assign out_dy    = dy_reg;
    assign out_slot  = slot_reg;

endmodule

// ===== rtl/aabb_collision_resolver.sv =====
// Box table with overlap resolution. A write (mode 0) stores one box and its
// collidable flag into a slot and returns nothing. A query (mode 1) walks all
// SLOTS entries through the box memory, one slot per cycle while the pipeline
// does not stall, and returns one transaction per hit (at most 32) in ascending
// slot order, the final one flagged with last; a query that hits nothing
// returns one empty transaction with last set. A query occupies the block
// through the slot walk over the single memory read port, then the read,
// pair, pending and output stages and the return to idle; a query box that
// cannot collide skips the walk, and stalls on the result side hold it longer.
// No new transaction is accepted until its final result has moved into the
// output register.
module aabb_collision_resolver #(
    parameter int SLOTS      = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [4:0]                   s_slot,
    input  logic                         s_skip_self,
    input  logic signed [COORD_BITS-1:0] s_box_left,
    input  logic signed [COORD_BITS-1:0] s_box_top,
    input  logic signed [COORD_BITS-1:0] s_box_right,
    input  logic signed [COORD_BITS-1:0] s_box_bottom,
    input  logic                         s_can_collide,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [4:0]                   m_other_slot,
    output logic signed [COORD_BITS:0]   m_correction_x,
    output logic signed [COORD_BITS:0]   m_correction_y,
    output logic signed [COORD_BITS:0]   m_penetration_x,
    output logic signed [COORD_BITS:0]   m_penetration_y,
    output logic [2:0]                   m_contact_side,
    output logic                         m_last
);
    import aabb_cr_pkg::*;

    localparam int CW          = COORD_BITS;
    localparam int OW          = COORD_BITS + 1;
    localparam int BOX_W       = 4 * COORD_BITS;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_RESULTS = 32;
    localparam int HCNT_W      = $clog2(MAX_RESULTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg, state_next;

    // box memory and per-slot flags
    logic [BOX_W-1:0] box_mem [SLOTS];
    logic [SLOTS-1:0] slot_valid_reg;
    logic [SLOTS-1:0] slot_coll_reg;

    // query box
    logic signed [CW-1:0] qa_left_reg, qa_top_reg, qa_right_reg, qa_bottom_reg;
    logic [4:0]           q_slot_reg;
    logic                 q_skip_reg;

    // walk control
    logic [CNT_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  addr_idx;
    logic [HCNT_W-1:0] hit_cnt_reg;

    // read stage
    logic              p1_valid_reg, p1_qual_reg;
    logic [IDX_W-1:0]  p1_slot_reg;
    logic [BOX_W-1:0]  rd_data_reg;

    // pair stage
    logic              p2_valid;
    pair_flags_t       p2_flags;
    logic signed [OW-1:0] p2_dx, p2_dy;
    logic [IDX_W-1:0]  p2_slot;

    // pending hit, held until it is known whether another follows
    logic              pend_valid_reg, pend_last_reg, pend_hit_reg;
    logic [4:0]        pend_slot_reg;
    logic signed [OW-1:0] pend_cx_reg, pend_cy_reg, pend_px_reg, pend_py_reg;
    logic [2:0]        pend_side_reg;

    // output register
    logic              out_valid_reg, out_hit_reg, out_last_reg;
    logic [4:0]        out_slot_reg;
    logic signed [OW-1:0] out_cx_reg, out_cy_reg, out_px_reg, out_py_reg;
    logic [2:0]        out_side_reg;

    logic in_fire, wr_fire, q_fire, slot_in_range;
    logic [IDX_W-1:0] wr_idx;
    logic issue_done, issue, adv, exhausted, out_free;
    logic p2_hit, pend_is_last, pend_move, take_hit, cap;

    // resolved fields for the hit at the pair stage
    logic sel_x, choose_x;
    logic signed [OW-1:0] res_px, res_py, res_cx, res_cy;
    logic [2:0] res_side;

    // handshake decode
    assign s_ready       = (state_reg == ST_IDLE);
    assign in_fire       = s_valid && s_ready;
    assign slot_in_range = 32'(s_slot) < SLOTS;
    assign wr_fire       = in_fire && (s_mode == MODE_WRITE) && slot_in_range;
    assign q_fire        = in_fire && (s_mode == MODE_QUERY);
    assign wr_idx        = IDX_W'(s_slot);

    // walk / pipeline control
    assign addr_idx     = addr_reg[IDX_W-1:0];
    assign issue_done   = (addr_reg == CNT_W'(SLOTS));
    assign out_free     = !out_valid_reg || m_ready;
    assign p2_hit       = p2_valid && p2_flags.hit_ok;
    assign exhausted    = (state_reg == ST_WALK) && issue_done &&
                          !p1_valid_reg && !p2_valid;
    assign pend_is_last = pend_last_reg || exhausted;
    assign pend_move    = pend_valid_reg && out_free && (pend_is_last || p2_hit);
    assign adv          = !(p2_hit && pend_valid_reg && !pend_move);
    assign issue        = (state_reg == ST_WALK) && !issue_done && adv;
    assign take_hit     = p2_hit && adv;
    assign cap          = take_hit && (hit_cnt_reg == HCNT_W'(MAX_RESULTS - 1));

    // state machine
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_fire) state_next = ST_WALK;
            end
            ST_WALK: begin
                if (cap || exhausted) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!pend_valid_reg) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // slot flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            slot_coll_reg  <= '0;
        end else if (wr_fire) begin
            slot_valid_reg[wr_idx] <= 1'b1;
            slot_coll_reg[wr_idx]  <= s_can_collide;
        end
    end

    // box memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            box_mem[wr_idx] <= {s_box_left, s_box_top, s_box_right, s_box_bottom};
        end
        if (issue) begin
            rd_data_reg <= box_mem[addr_idx];
        end
    end

    // query capture
    always_ff @(posedge aclk) begin
        if (q_fire) begin
            qa_left_reg   <= s_box_left;
            qa_top_reg    <= s_box_top;
            qa_right_reg  <= s_box_right;
            qa_bottom_reg <= s_box_bottom;
            q_slot_reg    <= s_slot;
            q_skip_reg    <= s_skip_self;
        end
    end

    // slot address and hit count; a non-collidable query starts exhausted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            hit_cnt_reg <= '0;
        end else begin
            if (q_fire) begin
                addr_reg <= s_can_collide ? '0 : CNT_W'(SLOTS);
            end else if (issue) begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (q_fire) begin
                hit_cnt_reg <= '0;
            end else if (take_hit) begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
        end
    end

    // read stage valid and qualification
    always_ff @(posedge aclk) begin
        if (!aresetn || cap) begin
            p1_valid_reg <= 1'b0;
        end else if (issue) begin
            p1_valid_reg <= 1'b1;
        end else if (adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            p1_slot_reg <= addr_idx;
            p1_qual_reg <= slot_valid_reg[addr_idx] && slot_coll_reg[addr_idx] &&
                           !(q_skip_reg && (32'(addr_idx) == 32'(q_slot_reg)));
        end
    end

    // pair test stage
    aabb_cr_geom #(
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (IDX_W)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .clear     (cap),
        .in_valid  (p1_valid_reg),
        .in_qual   (p1_qual_reg),
        .in_slot   (p1_slot_reg),
        .a_left    (qa_left_reg),
        .a_top     (qa_top_reg),
        .a_right   (qa_right_reg),
        .a_bottom  (qa_bottom_reg),
        .b_box     (rd_data_reg),
        .out_valid (p2_valid),
        .out_flags (p2_flags),
        .out_dx    (p2_dx),
        .out_dy    (p2_dy),
        .out_slot  (p2_slot)
    );

    // axis choice: containment first, else the smaller depth (ties go to y);
    // a zero y depth falls back to x
    always_comb begin
        if (p2_flags.contain_h) begin
            sel_x = 1'b0;
        end else if (p2_flags.contain_v) begin
            sel_x = 1'b1;
        end else begin
            sel_x = p2_dx < p2_dy;
        end
        choose_x = sel_x || (p2_dy == '0);
        res_px   = sel_x ? p2_dx : '0;
        if (choose_x) begin
            res_py   = '0;
            res_cx   = p2_flags.right ? res_px : -res_px;
            res_cy   = '0;
            res_side = p2_flags.right ? SIDE_RIGHT : SIDE_LEFT;
        end else begin
            res_py   = p2_dy;
            res_cx   = '0;
            res_cy   = p2_flags.below ? p2_dy : -p2_dy;
            res_side = p2_flags.below ? SIDE_TOP : SIDE_BOTTOM;
        end
    end

    // pending result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
        end else if (take_hit) begin
            pend_valid_reg <= 1'b1;
            pend_last_reg  <= cap;
        end else if (exhausted && !pend_valid_reg && (hit_cnt_reg == '0)) begin
            pend_valid_reg <= 1'b1;
            pend_last_reg  <= 1'b1;
        end else if (pend_move) begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
        end else if (exhausted) begin
            pend_last_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            pend_hit_reg  <= 1'b1;
            pend_slot_reg <= 5'(p2_slot);
            pend_cx_reg   <= res_cx;
            pend_cy_reg   <= res_cy;
            pend_px_reg   <= res_px;
            pend_py_reg   <= res_py;
            pend_side_reg <= res_side;
        end else if (exhausted && !pend_valid_reg) begin
            pend_hit_reg  <= 1'b0;
            pend_slot_reg <= '0;
            pend_cx_reg   <= '0;
            pend_cy_reg   <= '0;
            pend_px_reg   <= '0;
            pend_py_reg   <= '0;
            pend_side_reg <= SIDE_NONE;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_move) begin
            out_hit_reg  <= pend_hit_reg;
            out_last_reg <= pend_is_last;
            out_slot_reg <= pend_slot_reg;
            out_cx_reg   <= pend_cx_reg;
            out_cy_reg   <= pend_cy_reg;
            out_px_reg   <= pend_px_reg;
            out_py_reg   <= pend_py_reg;
            out_side_reg <= pend_side_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = out_hit_reg;
    assign m_other_slot    = out_slot_reg;
    assign m_correction_x  = out_cx_reg;
    assign m_correction_y  = out_cy_reg;
    assign m_penetration_x = out_px_reg;
    assign m_penetration_y = out_py_reg;
    assign m_contact_side  = out_side_reg;
    assign m_last          = out_last_reg;

endmodule
